// File: hw/rtl/nfcs_pkg.sv
// ----------------------------------------------------------------------------
// nfcs_pkg
// Types, constants and the control store of the NAND command sequencer.
// ----------------------------------------------------------------------------
package nfcs_pkg;

	// field widths at the ports
	localparam int OP_W     = 4;
	localparam int COL_W    = 12;
	localparam int PAGE_W   = 6;
	localparam int BLK_W    = 10;
	localparam int KIND_W   = 3;

	// address packing
	localparam int COLUMN_BITS = 12;
	localparam int PAGE_BITS   = 6;
	localparam int BLOCK_BITS  = 10;

	localparam int ID_BYTES_DEF = 5;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_WP_IDX = 1'b0;

	// operation codes
	localparam logic [OP_W-1:0] OP_RESET   = 4'd0;
	localparam logic [OP_W-1:0] OP_READ_ID = 4'd1;
	localparam logic [OP_W-1:0] OP_STATUS  = 4'd2;
	localparam logic [OP_W-1:0] OP_RSETUP  = 4'd3;
	localparam logic [OP_W-1:0] OP_ERASE   = 4'd4;
	localparam logic [OP_W-1:0] OP_PSETUP  = 4'd5;
	localparam logic [OP_W-1:0] OP_WRITE   = 4'd6;
	localparam logic [OP_W-1:0] OP_READ    = 4'd7;
	localparam logic [OP_W-1:0] OP_CONFIRM = 4'd8;
	localparam logic [OP_W-1:0] OP_END     = 4'd9;

	// NAND command bytes
	localparam logic [7:0] CMD_RESET   = 8'hFF;
	localparam logic [7:0] CMD_READ_ID = 8'h90;
	localparam logic [7:0] CMD_STATUS  = 8'h70;
	localparam logic [7:0] CMD_READ1   = 8'h00;
	localparam logic [7:0] CMD_READ2   = 8'h30;
	localparam logic [7:0] CMD_ERASE1  = 8'h60;
	localparam logic [7:0] CMD_ERASE2  = 8'hD0;
	localparam logic [7:0] CMD_PROG1   = 8'h80;
	localparam logic [7:0] CMD_PROG2   = 8'h10;
	localparam logic [7:0] ID_ADDR     = 8'h00;

	typedef enum logic [KIND_W-1:0] {
		K_CMD     = 3'd0,
		K_ADDR    = 3'd1,
		K_WRITE   = 3'd2,
		K_READ    = 3'd3,
		K_WAIT    = 3'd4,
		K_RELEASE = 3'd5
	} kind_t;

	// where the bus byte comes from
	typedef enum logic [2:0] {
		SRC_CONST  = 3'd0,
		SRC_COL_LO = 3'd1,
		SRC_COL_HI = 3'd2,
		SRC_ADDR3  = 3'd3,
		SRC_ADDR4  = 3'd4,
		SRC_ERASE3 = 3'd5,
		SRC_DATA   = 3'd6
	} src_t;

	typedef enum logic [1:0] {
		FLOW_NEXT = 2'd0,
		FLOW_LOOP = 2'd1,
		FLOW_JUMP = 2'd2,
		FLOW_END  = 2'd3
	} flow_t;

	localparam int STEP_W = 6;
	typedef logic [STEP_W-1:0] step_t;

	// program entry points
	localparam step_t EP_RESET   = 6'd0;
	localparam step_t EP_READ_ID = 6'd4;
	localparam step_t EP_STATUS  = 6'd8;
	localparam step_t EP_RSETUP  = 6'd12;
	localparam step_t EP_ERASE   = 6'd20;
	localparam step_t EP_PSETUP  = 6'd26;
	localparam step_t EP_WRITE   = 6'd32;
	localparam step_t EP_READ    = 6'd33;
	localparam step_t EP_CONFIRM = 6'd34;
	localparam step_t EP_END     = 6'd36;
	localparam step_t LAST_STEP  = 6'd36;

	typedef struct packed {
		kind_t      kind;
		src_t       src;
		logic [7:0] cbyte;
		flow_t      flow;
		step_t      target;
	} ucode_t;

	// one control word per bus cycle
	typedef struct packed {
		logic       valid;
		logic       chip;
		kind_t      kind;
		src_t       src;
		logic [7:0] cbyte;
		logic       last;
	} issue_t;

	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		unique case (step)
			// reset
			6'd0:  w = '{K_WAIT,    SRC_CONST,  8'h00,       FLOW_NEXT, EP_RESET};
			6'd1:  w = '{K_CMD,     SRC_CONST,  CMD_RESET,   FLOW_NEXT, EP_RESET};
			6'd2:  w = '{K_WAIT,    SRC_CONST,  8'h00,       FLOW_NEXT, EP_RESET};
			6'd3:  w = '{K_RELEASE, SRC_CONST,  8'h00,       FLOW_END,  EP_RESET};
			// read id
			6'd4:  w = '{K_CMD,     SRC_CONST,  CMD_READ_ID, FLOW_NEXT, EP_RESET};
			6'd5:  w = '{K_ADDR,    SRC_CONST,  ID_ADDR,     FLOW_NEXT, EP_RESET};
			6'd6:  w = '{K_READ,    SRC_CONST,  8'h00,       FLOW_LOOP, EP_RESET};
			6'd7:  w = '{K_RELEASE, SRC_CONST,  8'h00,       FLOW_END,  EP_RESET};
			// status, also the tail of erase and program confirm
			6'd8:  w = '{K_WAIT,    SRC_CONST,  8'h00,       FLOW_NEXT, EP_RESET};
			6'd9:  w = '{K_CMD,     SRC_CONST,  CMD_STATUS,  FLOW_NEXT, EP_RESET};
			6'd10: w = '{K_READ,    SRC_CONST,  8'h00,       FLOW_NEXT, EP_RESET};
			6'd11: w = '{K_RELEASE, SRC_CONST,  8'h00,       FLOW_END,  EP_RESET};
			// read setup
			6'd12: w = '{K_WAIT,    SRC_CONST,  8'h00,       FLOW_NEXT, EP_RESET};
			6'd13: w = '{K_CMD,     SRC_CONST,  CMD_READ1,   FLOW_NEXT, EP_RESET};
			6'd14: w = '{K_ADDR,    SRC_COL_LO, 8'h00,       FLOW_NEXT, EP_RESET};
			6'd15: w = '{K_ADDR,    SRC_COL_HI, 8'h00,       FLOW_NEXT, EP_RESET};
			6'd16: w = '{K_ADDR,    SRC_ADDR3,  8'h00,       FLOW_NEXT, EP_RESET};
			6'd17: w = '{K_ADDR,    SRC_ADDR4,  8'h00,       FLOW_NEXT, EP_RESET};
			6'd18: w = '{K_CMD,     SRC_CONST,  CMD_READ2,   FLOW_NEXT, EP_RESET};
			6'd19: w = '{K_WAIT,    SRC_CONST,  8'h00,       FLOW_END,  EP_RESET};
			// erase
			6'd20: w = '{K_WAIT,    SRC_CONST,  8'h00,       FLOW_NEXT, EP_RESET};
			6'd21: w = '{K_CMD,     SRC_CONST,  CMD_ERASE1,  FLOW_NEXT, EP_RESET};
			6'd22: w = '{K_ADDR,    SRC_ERASE3, 8'h00,       FLOW_NEXT, EP_RESET};
			6'd23: w = '{K_ADDR,    SRC_ADDR4,  8'h00,       FLOW_NEXT, EP_RESET};
			6'd24: w = '{K_CMD,     SRC_CONST,  CMD_ERASE2,  FLOW_NEXT, EP_RESET};
			6'd25: w = '{K_WAIT,    SRC_CONST,  8'h00,       FLOW_JUMP, EP_STATUS};
			// program setup
			6'd26: w = '{K_WAIT,    SRC_CONST,  8'h00,       FLOW_NEXT, EP_RESET};
			6'd27: w = '{K_CMD,     SRC_CONST,  CMD_PROG1,   FLOW_NEXT, EP_RESET};
			6'd28: w = '{K_ADDR,    SRC_COL_LO, 8'h00,       FLOW_NEXT, EP_RESET};
			6'd29: w = '{K_ADDR,    SRC_COL_HI, 8'h00,       FLOW_NEXT, EP_RESET};
			6'd30: w = '{K_ADDR,    SRC_ADDR3,  8'h00,       FLOW_NEXT, EP_RESET};
			6'd31: w = '{K_ADDR,    SRC_ADDR4,  8'h00,       FLOW_END,  EP_RESET};
			// data items
			6'd32: w = '{K_WRITE,   SRC_DATA,   8'h00,       FLOW_END,  EP_RESET};
			6'd33: w = '{K_READ,    SRC_CONST,  8'h00,       FLOW_END,  EP_RESET};
			// program confirm
			6'd34: w = '{K_CMD,     SRC_CONST,  CMD_PROG2,   FLOW_NEXT, EP_RESET};
			6'd35: w = '{K_WAIT,    SRC_CONST,  8'h00,       FLOW_JUMP, EP_STATUS};
			// end of transfer
			6'd36: w = '{K_RELEASE, SRC_CONST,  8'h00,       FLOW_END,  EP_RESET};
			default: w = '{K_RELEASE, SRC_CONST, 8'h00,      FLOW_END,  EP_RESET};
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/nfcs_apb.sv
// ----------------------------------------------------------------------------
// nfcs_apb
// Register port holding the write protect level.
// ----------------------------------------------------------------------------
module nfcs_apb
	import nfcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic              wp_level
);

	logic wp_q;
	logic wr_en;

	assign pready = 1'b1;
	// word index is the address bit above the byte offset
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_WP_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b1;
		end else if (wr_en) begin
			wp_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_WP_IDX) begin
			prdata[0] = wp_q;
		end
	end

	assign wp_level = wp_q;

endmodule

// File: hw/rtl/nfcs_sequencer.sv
// ----------------------------------------------------------------------------
// nfcs_sequencer
// Step counter over the control store, loop counter and transfer state.
// ----------------------------------------------------------------------------
module nfcs_sequencer
	import nfcs_pkg::*;
#(
	parameter int IdBytes = ID_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [OP_W-1:0] op,
	input  logic            chip,
	input  logic            adv,
	output logic            busy,
	output issue_t          issue
);

	localparam int CntW = (IdBytes > 1) ? $clog2(IdBytes) : 1;
	localparam logic [CntW-1:0] CntLast = CntW'(IdBytes - 1);

	logic            busy_q;
	step_t           step_q;
	logic [CntW-1:0] cnt_q;
	logic            active_chip_q;
	logic            xfer_open_q;

	ucode_t w;
	logic   cmd_op;
	logic   data_op;
	logic   start;
	step_t  entry;

	assign w = ucode_rom(step_q);

	always_comb begin
		cmd_op  = (op <= OP_PSETUP);
		data_op = (op >= OP_WRITE) && (op <= OP_END);
		start   = accept && (cmd_op || (data_op && xfer_open_q));
		unique case (op)
			OP_RESET:   entry = EP_RESET;
			OP_READ_ID: entry = EP_READ_ID;
			OP_STATUS:  entry = EP_STATUS;
			OP_RSETUP:  entry = EP_RSETUP;
			OP_ERASE:   entry = EP_ERASE;
			OP_PSETUP:  entry = EP_PSETUP;
			OP_WRITE:   entry = EP_WRITE;
			OP_READ:    entry = EP_READ;
			OP_CONFIRM: entry = EP_CONFIRM;
			OP_END:     entry = EP_END;
			default:    entry = EP_END;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			step_q        <= EP_RESET;
			cnt_q         <= '0;
			active_chip_q <= 1'b0;
			xfer_open_q   <= 1'b0;
		end else if (accept) begin
			// a new command closes any open transfer without a release
			if (cmd_op) begin
				active_chip_q <= chip;
				xfer_open_q   <= (op == OP_RSETUP) || (op == OP_PSETUP);
			end else if (op == OP_CONFIRM || op == OP_END) begin
				xfer_open_q <= 1'b0;
			end
			busy_q <= start;
			step_q <= entry;
			cnt_q  <= '0;
		end else if (busy_q && adv) begin
			case (w.flow)
				FLOW_NEXT: step_q <= step_q + 1'b1;
				FLOW_LOOP: begin
					if (cnt_q == CntLast) begin
						step_q <= step_q + 1'b1;
						cnt_q  <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				FLOW_JUMP: step_q <= w.target;
				FLOW_END:  busy_q <= 1'b0;
				default:   busy_q <= 1'b0;
			endcase
		end
	end

	assign busy = busy_q;

	always_comb begin
		issue.valid = busy_q;
		issue.chip  = active_chip_q;
		issue.kind  = w.kind;
		issue.src   = w.src;
		issue.cbyte = w.cbyte;
		issue.last  = (w.flow == FLOW_END);
	end

	a_end_stops: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && adv && (w.flow == FLOW_END) |=> !busy_q)
		else $error("sequencer kept running past the final step");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntLast)
		else $error("id read counter out of range");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= LAST_STEP)
		else $error("step counter outside the program");

	a_hold_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !adv |=> $stable(step_q) && $stable(cnt_q))
		else $error("step moved while the output was held");

endmodule

// File: hw/rtl/nfcs_datapath.sv
// ----------------------------------------------------------------------------
// nfcs_datapath
// Address capture, bus byte selection and the output register.
// ----------------------------------------------------------------------------
module nfcs_datapath
	import nfcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [BLK_W-1:0]  block_addr,
	input  logic [PAGE_W-1:0] page_addr,
	input  logic [COL_W-1:0]  column_addr,
	input  logic [7:0]        data_byte,
	input  issue_t            issue,
	input  logic              wp_level,
	input  logic              out_stall,
	output logic              adv,
	output logic              out_valid,
	output logic [KIND_W-1:0] cycle_kind,
	output logic              chip_select,
	output logic [7:0]        bus_byte,
	output logic              protect_level,
	output logic              last_of_run
);

	logic [BLK_W-1:0]  block_q;
	logic [PAGE_W-1:0] page_q;
	logic [COL_W-1:0]  column_q;
	logic [7:0]        data_q;

	logic              out_valid_q;
	kind_t             kind_q;
	logic              chip_q;
	logic [7:0]        byte_q;
	logic              wp_q;
	logic              last_q;

	logic [BLOCK_BITS-1:0] blk;
	logic [7:0]            byte_sel;

	always_ff @(posedge clk) begin
		if (load) begin
			block_q  <= block_addr;
			page_q   <= page_addr;
			column_q <= column_addr;
			data_q   <= data_byte;
		end
	end

	assign blk = block_q[BLOCK_BITS-1:0];

	always_comb begin
		case (issue.src)
			SRC_CONST:  byte_sel = issue.cbyte;
			SRC_COL_LO: byte_sel = column_q[7:0];
			SRC_COL_HI: byte_sel = 8'(column_q[COLUMN_BITS-1:8]);
			// low block bits sit above the page
			SRC_ADDR3:  byte_sel = 8'({blk, page_q[PAGE_BITS-1:0]});
			SRC_ADDR4:  byte_sel = 8'(blk >> (8 - PAGE_BITS));
			SRC_ERASE3: byte_sel = 8'({blk, PAGE_BITS'(0)});
			SRC_DATA:   byte_sel = data_q;
			default:    byte_sel = 8'h00;
		endcase
	end

	assign adv = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= issue.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && issue.valid) begin
			kind_q <= issue.kind;
			chip_q <= issue.chip;
			byte_q <= byte_sel;
			wp_q   <= wp_level;
			last_q <= issue.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign cycle_kind    = kind_q;
	assign chip_select   = chip_q;
	assign bus_byte      = byte_q;
	assign protect_level = wp_q;
	assign last_of_run   = last_q;

endmodule

// File: hw/rtl/nand_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// nand_flash_command_sequencer
// Expands NAND operation requests for two chips into runs of bus cycles.
// ----------------------------------------------------------------------------
// Each accepted request is played out of a small control store, one bus
// cycle per clock into the output register unless out_stall holds it back;
// write byte and read byte give their data cycle and end a release, and the
// other operations a run of bus cycles. The step counter reads one control
// word a clock while the output advances, so a request occupies the block
// until its last word enters the output register; a data item, confirm or
// end with no open transfer, and an unused op code, give nothing. The next
// request is taken while the last result waits in the output register.
// Write protect sits at byte address 0.
// ----------------------------------------------------------------------------
module nand_flash_command_sequencer
	import nfcs_pkg::*;
#(
	parameter int ID_BYTES = ID_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [OP_W-1:0]   op,
	input  logic              chip,
	input  logic [BLK_W-1:0]  block_addr,
	input  logic [PAGE_W-1:0] page_addr,
	input  logic [COL_W-1:0]  column_addr,
	input  logic [7:0]        data_byte,
	// bus cycle channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KIND_W-1:0] cycle_kind,
	output logic              chip_select,
	output logic [7:0]        bus_byte,
	output logic              protect_level,
	output logic              last_of_run,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic   accept;
	logic   busy;
	logic   adv;
	logic   wp_level;
	issue_t issue;

	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	nfcs_apb u_apb (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.wp_level (wp_level)
	);

	nfcs_sequencer #(
		.IdBytes (ID_BYTES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.op     (op),
		.chip   (chip),
		.adv    (adv),
		.busy   (busy),
		.issue  (issue)
	);

	nfcs_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.block_addr    (block_addr),
		.page_addr     (page_addr),
		.column_addr   (column_addr),
		.data_byte     (data_byte),
		.issue         (issue),
		.wp_level      (wp_level),
		.out_stall     (out_stall),
		.adv           (adv),
		.out_valid     (out_valid),
		.cycle_kind    (cycle_kind),
		.chip_select   (chip_select),
		.bus_byte      (bus_byte),
		.protect_level (protect_level),
		.last_of_run   (last_of_run)
	);

endmodule

// File: tb/tb_nand_flash_command_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nand_flash_command_sequencer
// Self-checking bench for the two-chip NAND command sequencer.
// ----------------------------------------------------------------------------
// Requests go in through the valid/stall channel, and a scoreboard expands
// each accepted one into the bus cycles it should cause. Every bus cycle that
// leaves the block is checked against the oldest expected one. A directed
// opening covers each operation, the address extremes, dropped data items,
// unused op codes and commands that cut an open transfer. Random phases follow,
// made mostly of program and read transfers with random content, with the
// write protect level changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_nand_flash_command_sequencer;
	import nfcs_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 24;
	localparam int IDLE_PERCENT  = 35;
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd10;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;
	localparam logic [APB_AW-1:0] WP_ADDR = APB_AW'(4 * REG_WP_IDX);

	typedef struct {
		logic [OP_W-1:0]   op;
		logic              chip;
		logic [BLK_W-1:0]  blk;
		logic [PAGE_W-1:0] page;
		logic [COL_W-1:0]  col;
		logic [7:0]        data;
	} request_t;

	typedef struct {
		kind_t      kind;
		logic       chip;
		logic [7:0] bus;
		logic       prot;
		logic       last;
	} bus_cycle_t;

	class bus_cycle_scoreboard;
		logic         wp_level;
		logic         cur_chip;
		logic         xfer_open;
		bus_cycle_t   expected_q[$];
		int           errors;

		function new();
			wp_level  = 1'b1;
			cur_chip  = 1'b0;
			xfer_open = 1'b0;
			errors    = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void push(kind_t k, logic [7:0] b);
			bus_cycle_t c;
			c.kind = k;
			c.chip = cur_chip;
			c.bus  = b;
			c.prot = wp_level;
			c.last = 1'b0;
			expected_q.push_back(c);
		endfunction

		function void push_status();
			push(K_WAIT, 8'h00);
			push(K_CMD, CMD_STATUS);
			push(K_READ, 8'h00);
			push(K_RELEASE, 8'h00);
		endfunction

		// column low, column high, block low with page, block high
		function void push_address(request_t r);
			push(K_ADDR, r.col[7:0]);
			push(K_ADDR, 8'(r.col >> 8));
			push(K_ADDR, 8'({r.blk, r.page}));
			push(K_ADDR, 8'(r.blk >> (8 - PAGE_BITS)));
		endfunction

		// expands one accepted request, returns the number of bus cycles due
		function int note_request(request_t r);
			int n_before;
			n_before = expected_q.size();
			// any command drops an open transfer without a release
			if (r.op <= OP_PSETUP) begin
				cur_chip  = r.chip;
				xfer_open = 1'b0;
			end
			case (r.op)
				OP_RESET: begin
					push(K_WAIT, 8'h00);
					push(K_CMD, CMD_RESET);
					push(K_WAIT, 8'h00);
					push(K_RELEASE, 8'h00);
				end
				OP_READ_ID: begin
					push(K_CMD, CMD_READ_ID);
					push(K_ADDR, ID_ADDR);
					for (int i = 0; i < ID_BYTES_DEF; i++)
						push(K_READ, 8'h00);
					push(K_RELEASE, 8'h00);
				end
				OP_STATUS: push_status();
				OP_RSETUP: begin
					push(K_WAIT, 8'h00);
					push(K_CMD, CMD_READ1);
					push_address(r);
					push(K_CMD, CMD_READ2);
					push(K_WAIT, 8'h00);
					xfer_open = 1'b1;
				end
				OP_ERASE: begin
					push(K_WAIT, 8'h00);
					push(K_CMD, CMD_ERASE1);
					push(K_ADDR, 8'(r.blk << PAGE_BITS));
					push(K_ADDR, 8'(r.blk >> (8 - PAGE_BITS)));
					push(K_CMD, CMD_ERASE2);
					push(K_WAIT, 8'h00);
					push_status();
				end
				OP_PSETUP: begin
					push(K_WAIT, 8'h00);
					push(K_CMD, CMD_PROG1);
					push_address(r);
					xfer_open = 1'b1;
				end
				OP_WRITE: if (xfer_open) push(K_WRITE, r.data);
				OP_READ: if (xfer_open) push(K_READ, 8'h00);
				OP_CONFIRM: begin
					if (xfer_open) begin
						push(K_CMD, CMD_PROG2);
						push(K_WAIT, 8'h00);
						push_status();
						xfer_open = 1'b0;
					end
				end
				OP_END: begin
					if (xfer_open) begin
						push(K_RELEASE, 8'h00);
						xfer_open = 1'b0;
					end
				end
				default: ;
			endcase
			if (expected_q.size() > n_before)
				expected_q[$].last = 1'b1;
			return expected_q.size() - n_before;
		endfunction

		function void check_cycle(bus_cycle_t got);
			bus_cycle_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected bus cycle, expected none, got kind %0d byte %02h",
					$time, got.kind, got.bus);
				return;
			end
			want = expected_q.pop_front();
			if (got.kind !== want.kind) begin
				errors++;
				$display("%0t: cycle_kind expected %0d got %0d", $time, want.kind, got.kind);
			end
			if (got.chip !== want.chip) begin
				errors++;
				$display("%0t: chip_select expected %0b got %0b", $time, want.chip, got.chip);
			end
			if (got.bus !== want.bus) begin
				errors++;
				$display("%0t: bus_byte expected %02h got %02h", $time, want.bus, got.bus);
			end
			if (got.prot !== want.prot) begin
				errors++;
				$display("%0t: protect_level expected %0b got %0b", $time, want.prot, got.prot);
			end
			if (got.last !== want.last) begin
				errors++;
				$display("%0t: last_of_run expected %0b got %0b", $time, want.last, got.last);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [OP_W-1:0]   op = OP_RESET;
	logic              chip = 1'b0;
	logic [BLK_W-1:0]  block_addr = '0;
	logic [PAGE_W-1:0] page_addr = '0;
	logic [COL_W-1:0]  column_addr = '0;
	logic [7:0]        data_byte = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [KIND_W-1:0] cycle_kind;
	logic              chip_select;
	logic [7:0]        bus_byte;
	logic              protect_level;
	logic              last_of_run;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bus_cycle_scoreboard sb = new();
	bit calm = 1'b0;
	int busy_items = 0;
	int cycle_count = 0;

	nand_flash_command_sequencer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.chip         (chip),
		.block_addr   (block_addr),
		.page_addr    (page_addr),
		.column_addr  (column_addr),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cycle_kind   (cycle_kind),
		.chip_select  (chip_select),
		.bus_byte     (bus_byte),
		.protect_level(protect_level),
		.last_of_run  (last_of_run),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// bus cycle side: values read just after the edge are those the edge saw
	initial begin
		bus_cycle_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.kind = kind_t'(cycle_kind);
				got.chip = chip_select;
				got.bus  = bus_byte;
				got.prot = protect_level;
				got.last = last_of_run;
				sb.check_cycle(got);
			end
			out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	function automatic request_t make_request(logic [OP_W-1:0] o, logic c,
		logic [BLK_W-1:0] b, logic [PAGE_W-1:0] p, logic [COL_W-1:0] col, logic [7:0] d);
		request_t r;
		r.op   = o;
		r.chip = c;
		r.blk  = b;
		r.page = p;
		r.col  = col;
		r.data = d;
		return r;
	endfunction

	function automatic request_t random_request(logic [OP_W-1:0] o);
		return make_request(o, 1'($urandom_range(1)), BLK_W'($urandom),
			PAGE_W'($urandom), COL_W'($urandom), 8'($urandom));
	endfunction

	task automatic send_request(input request_t r);
		// valid stays high between back-to-back transactions
		if (!calm)
			while ($urandom_range(99) < IDLE_PERCENT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid    <= 1'b1;
		op          <= r.op;
		chip        <= r.chip;
		block_addr  <= r.blk;
		page_addr   <= r.page;
		column_addr <= r.col;
		data_byte   <= r.data;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (sb.note_request(r) > 0)
			busy_items++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// dropped items may still occupy the block after the last bus cycle
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_protect(input logic level);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= WP_ADDR;
		pwdata  <= APB_DW'(level);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.wp_level = level;
	endtask

	task automatic send_data_items(input int n, input int read_percent);
		for (int i = 0; i < n; i++)
			send_request(random_request(($urandom_range(99) < read_percent) ?
				OP_READ : OP_WRITE));
	endtask

	task automatic run_random(input int target);
		int start;
		int pick;
		start = busy_items;
		while (busy_items - start < target) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				// program transfer, closed by confirm, end, or left for a command to cut
				send_request(random_request(OP_PSETUP));
				send_data_items($urandom_range(6), 10);
				pick = $urandom_range(99);
				if (pick < 70)
					send_request(random_request(OP_CONFIRM));
				else if (pick < 85)
					send_request(random_request(OP_END));
			end else if (pick < 60) begin
				send_request(random_request(OP_RSETUP));
				send_data_items($urandom_range(6), 85);
				if ($urandom_range(99) < 80)
					send_request(random_request(OP_END));
			end else if (pick < 85) begin
				send_request(random_request(4'($urandom_range(OP_RESET, OP_ERASE))));
			end else begin
				send_request(random_request(4'($urandom_range(OP_UNUSED_HI))));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening, write protect still at its reset level
		send_request(make_request(OP_RESET, 1'b0, '0, '0, '0, 8'h00));
		send_request(make_request(OP_RESET, 1'b1, '1, '1, '1, 8'hff));
		send_request(make_request(OP_READ_ID, 1'b1, '0, '0, '0, 8'h00));
		send_request(make_request(OP_STATUS, 1'b0, '0, '0, '0, 8'h00));
		// data, confirm and end with nothing open are dropped
		send_request(make_request(OP_WRITE, 1'b1, '0, '0, '0, 8'h5a));
		send_request(make_request(OP_READ, 1'b1, '0, '0, '0, 8'h00));
		send_request(make_request(OP_CONFIRM, 1'b1, '0, '0, '0, 8'h00));
		send_request(make_request(OP_END, 1'b1, '0, '0, '0, 8'h00));
		send_request(make_request(OP_UNUSED_LO, 1'b1, '1, '1, '1, 8'hff));
		send_request(make_request(OP_UNUSED_HI, 1'b0, '1, '1, '1, 8'hff));
		send_request(make_request(OP_RSETUP, 1'b1, '1, '1, '1, 8'h00));
		send_request(make_request(OP_READ, 1'b0, '0, '0, '0, 8'h00));
		send_request(make_request(OP_WRITE, 1'b0, '0, '0, '0, 8'hff));
		send_request(make_request(OP_END, 1'b0, '0, '0, '0, 8'h00));
		send_request(make_request(OP_PSETUP, 1'b0, '0, '0, '0, 8'h00));
		send_request(make_request(OP_WRITE, 1'b1, '1, '1, '1, 8'h00));
		send_request(make_request(OP_WRITE, 1'b1, '0, '0, '0, 8'ha5));
		send_request(make_request(OP_READ, 1'b1, '0, '0, '0, 8'h00));
		send_request(make_request(OP_CONFIRM, 1'b1, '0, '0, '0, 8'h00));
		send_request(make_request(OP_ERASE, 1'b1, '1, '1, '1, 8'h00));
		send_request(make_request(OP_ERASE, 1'b0, '0, '0, '0, 8'h00));
		// a command cuts the open program transfer
		send_request(make_request(OP_PSETUP, 1'b1, 10'h2aa, 6'h15, 12'h555, 8'h00));
		send_request(make_request(OP_STATUS, 1'b0, '0, '0, '0, 8'h00));
		send_request(make_request(OP_WRITE, 1'b1, '0, '0, '0, 8'h3c));
		send_request(make_request(OP_RSETUP, 1'b0, 10'h155, 6'h2a, 12'haaa, 8'h00));
		send_request(make_request(OP_END, 1'b1, '0, '0, '0, 8'h00));
		settle();

		write_protect(1'b0);
		run_random(80);
		settle();

		// back-to-back stretch with no idling on either side
		write_protect(1'b1);
		calm = 1'b1;
		run_random(80);
		settle();
		calm = 1'b0;

		write_protect(1'b0);
		run_random(80);
		settle();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
